// ----- design/tbe_pkg.sv -----
// Shared types, constants and the round mixing function of the TEA block encrypt unit.
`timescale 1ns / 1ps
`default_nettype none

package tbe_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumKeys = 4;
  localparam int unsigned CfgAddrW = 8;
  localparam logic [WordW-1:0] KeyStep = 32'hbadd1917;

  localparam logic [CfgAddrW-1:0] RegKey0 = 8'd0;
  localparam logic [CfgAddrW-1:0] RegKey1 = 8'd1;
  localparam logic [CfgAddrW-1:0] RegKey2 = 8'd2;
  localparam logic [CfgAddrW-1:0] RegKey3 = 8'd3;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t second;
    word_t first;
  } blk_t;

  typedef struct packed {
    word_t k3;
    word_t k2;
    word_t k1;
    word_t k0;
  } key_t;

  function automatic word_t mix_word(word_t w, word_t sum, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (w << 4) + ka;
    b = w + sum;
    c = (w >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

`default_nettype wire

// ----- design/tbe_round_cell.sv -----
// One half-round cell of the encryption chain, with its own valid bit and stall logic.
`timescale 1ns / 1ps
`default_nettype none

module tbe_round_cell #(
  parameter logic [31:0] SumVal = 32'h0,
  parameter bit SecondHalf = 1'b0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire tbe_pkg::key_t key,
  input  wire logic         up_valid,
  input  wire tbe_pkg::blk_t up_blk,
  output logic              up_ready,
  output logic              dn_valid,
  output tbe_pkg::blk_t     dn_blk,
  input  wire logic         dn_ready
);
  import tbe_pkg::*;

  logic  valid_r;
  blk_t  blk_r;
  blk_t  blk_nxt;
  word_t mix;

  always_comb begin
    if (SecondHalf) begin
      mix = mix_word(up_blk.first, SumVal, key.k2, key.k3);
      blk_nxt.first = up_blk.first;
      blk_nxt.second = up_blk.second + mix;
    end else begin
      mix = mix_word(up_blk.second, SumVal, key.k0, key.k1);
      blk_nxt.first = up_blk.first + mix;
      blk_nxt.second = up_blk.second;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk_r <= blk_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_blk = blk_r;

endmodule

`default_nettype wire

// ----- design/tea_block_encrypt_unit.sv -----
// Top level of the TEA block encrypt unit: key registers and the chain of round cells.
`timescale 1ns / 1ps
`default_nettype none

// Encrypts one 64-bit block per beat with ROUNDS TEA-style rounds under a 128-bit key
// written through the cfg port (registers 0 to 3, other indexes are ignored).
// Each round is split over two registered cells of a chain, and one block enters
// per cycle while the chain is not stalled. Every cell stalls only when it and all
// cells after it are full, so gaps in the chain close up while a result waits at
// the output.

module tea_block_encrypt_unit #(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tbe_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [31:0]                   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: plain_first[31:0], plain_second[63:32].
  input  wire logic [63:0]                   in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // Fields from bit 0: cipher_first[31:0], cipher_second[63:32].
  output logic [63:0]                        out_tdata
);
  import tbe_pkg::*;

  localparam int unsigned NumCells = 2 * ROUNDS;

  key_t key_r;
  logic [NumCells:0] vld;
  logic [NumCells:0] rdy;
  blk_t blk [NumCells+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        RegKey0: key_r.k0 <= cfg_wdata;
        RegKey1: key_r.k1 <= cfg_wdata;
        RegKey2: key_r.k2 <= cfg_wdata;
        RegKey3: key_r.k3 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign vld[0] = in_tvalid;
  assign blk[0] = blk_t'(in_tdata);
  assign in_tready = rdy[0];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    localparam logic [63:0] RoundSum = 64'(KeyStep) * 64'((i / 2) + 1);
    tbe_round_cell #(
      .SumVal(RoundSum[31:0]),
      .SecondHalf((i % 2) == 1)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .key(key_r),
      .up_valid(vld[i]),
      .up_blk(blk[i]),
      .up_ready(rdy[i]),
      .dn_valid(vld[i+1]),
      .dn_blk(blk[i+1]),
      .dn_ready(rdy[i+1])
    );
  end

  assign rdy[NumCells] = out_tready;
  assign out_tvalid = vld[NumCells];
  assign out_tdata = 64'(blk[NumCells]);

  a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the result slot is empty");

  a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!(&vld[NumCells:1]) || out_tready))
    else $error("input ready does not match chain occupancy");

  a_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld[NumCells:1]) < $past($countones(vld[NumCells:1]))
      |-> $past(out_tvalid && out_tready))
    else $error("block dropped from the chain");

  a_fill_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld[1])
    else $error("accepted beat did not enter the first cell");

endmodule

`default_nettype wire
